// ===== sv/isb_pkg.sv =====
package isb_pkg;

  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned FracBits  = 16;

  localparam int unsigned ColBits      = $clog2(MaxWidth);
  localparam int unsigned RowBits      = $clog2(MaxHeight);
  localparam int unsigned IndexBits    = 12;
  localparam int unsigned StepBits     = 24;
  localparam int unsigned SizeBits     = 10;
  localparam int unsigned PosBits      = IndexBits + StepBits;
  localparam int unsigned PixelBits    = 24;
  localparam int unsigned BankAddrBits = ColBits + RowBits - 2;
  localparam int unsigned BankDepth    = 1 << BankAddrBits;
  localparam int unsigned WeightBits   = 2 * FracBits + 1;
  localparam int unsigned ProdBits     = 2 * FracBits + 8;
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 24;

  localparam logic [CfgIndexBits-1:0] CfgSourceWidth  = 3'd0;
  localparam logic [CfgIndexBits-1:0] CfgSourceHeight = 3'd1;
  localparam logic [CfgIndexBits-1:0] CfgColumnStep   = 3'd2;
  localparam logic [CfgIndexBits-1:0] CfgRowStep      = 3'd3;
  localparam logic [CfgIndexBits-1:0] CfgColorMode    = 3'd4;

  localparam logic ActLoad    = 1'b0;
  localparam logic ActRequest = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [IndexBits-1:0] row_index;
    logic [IndexBits-1:0] column_index;
    logic [7:0]           channel_zero;
    logic [7:0]           channel_one;
    logic [7:0]           channel_two;
  } item_t;

  typedef struct packed {
    logic [7:0] out_channel_zero;
    logic [7:0] out_channel_one;
    logic [7:0] out_channel_two;
  } result_t;

  typedef struct packed {
    logic [SizeBits-1:0] source_width;
    logic [SizeBits-1:0] source_height;
    logic [StepBits-1:0] column_step;
    logic [StepBits-1:0] row_step;
    logic                color_mode;
  } cfg_t;

  // Mapped coordinates for a request, or the write beat for a load.
  typedef struct packed {
    logic                 valid;
    logic                 action;
    logic [IndexBits-1:0] row_index;
    logic [IndexBits-1:0] column_index;
    logic [PixelBits-1:0] pixel;
    logic [RowBits-1:0]   top;
    logic [RowBits-1:0]   bottom;
    logic [ColBits-1:0]   left;
    logic [ColBits-1:0]   right;
    logic [FracBits-1:0]  frac_col;
    logic [FracBits-1:0]  frac_row;
  } coord_t;

  typedef struct packed {
    logic                          valid;
    logic [FracBits-1:0]           frac_col;
    logic [FracBits-1:0]           frac_row;
    logic                          top_par;
    logic                          bottom_par;
    logic                          left_par;
    logic                          right_par;
    logic [3:0][PixelBits-1:0]     bank_data;
  } tap_t;

endpackage

// ===== sv/isb_ram.sv =====
module isb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/isb_coord.sv =====
module isb_coord (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  isb_pkg::item_t item_i,
  input  isb_pkg::cfg_t  cfg_i,
  output isb_pkg::coord_t coord_o
);

  logic                              s1_valid_q;
  isb_pkg::item_t                    s1_item_q;
  logic                              s2_valid_q;
  isb_pkg::item_t                    s2_item_q;
  logic [isb_pkg::PosBits-1:0]       pos_col_q, pos_row_q;
  logic [isb_pkg::SizeBits-1:0]      width_eff, height_eff;
  logic [isb_pkg::PosBits-1:0]       last_col, last_row, clip_col, clip_row;
  logic [isb_pkg::FracBits-1:0]      fc, fr;
  logic [isb_pkg::ColBits-1:0]       lo_col;
  logic [isb_pkg::RowBits-1:0]       lo_row;
  isb_pkg::coord_t                   coord_d, coord_q;

  always_comb begin
    width_eff = cfg_i.source_width;
    if (cfg_i.source_width == '0) begin
      width_eff = isb_pkg::SizeBits'(1);
    end else if (cfg_i.source_width > isb_pkg::SizeBits'(isb_pkg::MaxWidth)) begin
      width_eff = isb_pkg::SizeBits'(isb_pkg::MaxWidth);
    end
    height_eff = cfg_i.source_height;
    if (cfg_i.source_height == '0) begin
      height_eff = isb_pkg::SizeBits'(1);
    end else if (cfg_i.source_height > isb_pkg::SizeBits'(isb_pkg::MaxHeight)) begin
      height_eff = isb_pkg::SizeBits'(isb_pkg::MaxHeight);
    end
    last_col = isb_pkg::PosBits'(width_eff - 1'b1) << isb_pkg::FracBits;
    last_row = isb_pkg::PosBits'(height_eff - 1'b1) << isb_pkg::FracBits;
    clip_col = (pos_col_q > last_col) ? last_col : pos_col_q;
    clip_row = (pos_row_q > last_row) ? last_row : pos_row_q;
    fc     = clip_col[isb_pkg::FracBits-1:0];
    fr     = clip_row[isb_pkg::FracBits-1:0];
    lo_col = clip_col[isb_pkg::FracBits+isb_pkg::ColBits-1:isb_pkg::FracBits];
    lo_row = clip_row[isb_pkg::FracBits+isb_pkg::RowBits-1:isb_pkg::FracBits];

    coord_d.valid        = s2_valid_q;
    coord_d.action       = s2_item_q.action;
    coord_d.row_index    = s2_item_q.row_index;
    coord_d.column_index = s2_item_q.column_index;
    coord_d.pixel        = {s2_item_q.channel_two, s2_item_q.channel_one,
                            s2_item_q.channel_zero};
    coord_d.left         = lo_col;
    coord_d.right        = lo_col + isb_pkg::ColBits'(fc != '0);
    coord_d.top          = lo_row;
    coord_d.bottom       = lo_row + isb_pkg::RowBits'(fr != '0);
    coord_d.frac_col     = fc;
    coord_d.frac_row     = fr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      coord_q    <= '0;
    end else begin
      s1_valid_q <= start_i;
      s2_valid_q <= s1_valid_q;
      coord_q    <= coord_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_i;
    s2_item_q <= s1_item_q;
    pos_col_q <= isb_pkg::PosBits'(s1_item_q.column_index)
               * isb_pkg::PosBits'(cfg_i.column_step);
    pos_row_q <= isb_pkg::PosBits'(s1_item_q.row_index)
               * isb_pkg::PosBits'(cfg_i.row_step);
  end

  assign coord_o = coord_q;

endmodule

// ===== sv/isb_store.sv =====
module isb_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  isb_pkg::coord_t coord_i,
  output isb_pkg::tap_t   tap_o
);

  logic                                wr_en;
  logic [isb_pkg::BankAddrBits-1:0]    waddr;
  logic [3:0][isb_pkg::PixelBits-1:0]  rdata;
  logic                                valid_q;
  logic [isb_pkg::FracBits-1:0]        fc_q, fr_q;
  logic                                tp_q, bp_q, lp_q, rp_q;

  // Loads outside the store are dropped; the store is split in four banks by
  // row and column parity so the four neighbors are read in the same cycle.
  assign wr_en = coord_i.valid && (coord_i.action == isb_pkg::ActLoad)
              && (coord_i.row_index < isb_pkg::IndexBits'(isb_pkg::MaxHeight))
              && (coord_i.column_index < isb_pkg::IndexBits'(isb_pkg::MaxWidth));
  assign waddr = {coord_i.row_index[isb_pkg::RowBits-1:1],
                  coord_i.column_index[isb_pkg::ColBits-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RowPar = 1'((b >> 1) & 1);
    localparam logic ColPar = 1'(b & 1);
    logic [isb_pkg::RowBits-1:0]      rsel;
    logic [isb_pkg::ColBits-1:0]      csel;
    logic [isb_pkg::BankAddrBits-1:0] raddr;
    logic                             bank_we;

    assign rsel    = (coord_i.top[0] == RowPar) ? coord_i.top : coord_i.bottom;
    assign csel    = (coord_i.left[0] == ColPar) ? coord_i.left : coord_i.right;
    assign raddr   = {rsel[isb_pkg::RowBits-1:1], csel[isb_pkg::ColBits-1:1]};
    assign bank_we = wr_en && (coord_i.row_index[0] == RowPar)
                  && (coord_i.column_index[0] == ColPar);

    isb_ram #(
      .Width(isb_pkg::PixelBits),
      .Depth(isb_pkg::BankDepth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (bank_we),
      .waddr_i(waddr),
      .wdata_i(coord_i.pixel),
      .raddr_i(raddr),
      .rdata_o(rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= coord_i.valid && (coord_i.action == isb_pkg::ActRequest);
    end
  end

  always_ff @(posedge clk_i) begin
    fc_q <= coord_i.frac_col;
    fr_q <= coord_i.frac_row;
    tp_q <= coord_i.top[0];
    bp_q <= coord_i.bottom[0];
    lp_q <= coord_i.left[0];
    rp_q <= coord_i.right[0];
  end

  always_comb begin
    tap_o.valid      = valid_q;
    tap_o.frac_col   = fc_q;
    tap_o.frac_row   = fr_q;
    tap_o.top_par    = tp_q;
    tap_o.bottom_par = bp_q;
    tap_o.left_par   = lp_q;
    tap_o.right_par  = rp_q;
    tap_o.bank_data  = rdata;
  end

endmodule

// ===== sv/isb_blend.sv =====
module isb_blend (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isb_pkg::tap_t    tap_i,
  input  logic             color_mode_i,
  output logic             result_valid_o,
  output isb_pkg::result_t result_o
);

  localparam int unsigned WSumBits = isb_pkg::WeightBits + 1;

  logic [isb_pkg::FracBits:0]         one_fc, one_fr;
  logic [isb_pkg::FracBits:0]         fc_ext, fr_ext;
  logic                               v5_q, v6_q, v7_q;
  logic [3:0][isb_pkg::WeightBits-1:0] w_q;
  logic [3:0][isb_pkg::PixelBits-1:0]  p_q;
  logic [2:0][3:0][isb_pkg::ProdBits-1:0] prod_q;
  logic [2:0][isb_pkg::ProdBits-1:0]  sum;
  isb_pkg::result_t                   res_d, res_q;

  assign fc_ext = {1'b0, tap_i.frac_col};
  assign fr_ext = {1'b0, tap_i.frac_row};
  assign one_fc = {1'b1, {isb_pkg::FracBits{1'b0}}} - fc_ext;
  assign one_fr = {1'b1, {isb_pkg::FracBits{1'b0}}} - fr_ext;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = prod_q[c][0] + prod_q[c][1] + prod_q[c][2] + prod_q[c][3];
    end
    res_d.out_channel_zero = sum[0][2*isb_pkg::FracBits +: 8];
    res_d.out_channel_one  = color_mode_i ? sum[1][2*isb_pkg::FracBits +: 8] : 8'd0;
    res_d.out_channel_two  = color_mode_i ? sum[2][2*isb_pkg::FracBits +: 8] : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v5_q <= tap_i.valid;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // Weights: index 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
    w_q[0] <= isb_pkg::WeightBits'(one_fr) * isb_pkg::WeightBits'(one_fc);
    w_q[1] <= isb_pkg::WeightBits'(one_fr) * isb_pkg::WeightBits'(fc_ext);
    w_q[2] <= isb_pkg::WeightBits'(fr_ext) * isb_pkg::WeightBits'(one_fc);
    w_q[3] <= isb_pkg::WeightBits'(fr_ext) * isb_pkg::WeightBits'(fc_ext);
    p_q[0] <= tap_i.bank_data[{tap_i.top_par, tap_i.left_par}];
    p_q[1] <= tap_i.bank_data[{tap_i.top_par, tap_i.right_par}];
    p_q[2] <= tap_i.bank_data[{tap_i.bottom_par, tap_i.left_par}];
    p_q[3] <= tap_i.bank_data[{tap_i.bottom_par, tap_i.right_par}];
    for (int c = 0; c < 3; c++) begin
      for (int n = 0; n < 4; n++) begin
        prod_q[c][n] <= isb_pkg::ProdBits'(w_q[n])
                      * isb_pkg::ProdBits'(p_q[n][8*c +: 8]);
      end
    end
    res_q <= res_d;
  end

  assign result_valid_o = v7_q;
  assign result_o       = res_q;

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> ($past(WSumBits'(w_q[0]) + WSumBits'(w_q[1]) + WSumBits'(w_q[2])
                    + WSumBits'(w_q[3])) == (WSumBits'(1) << (2*isb_pkg::FracBits))))
    else $error("bilinear weights do not sum to one");

  a_gray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !color_mode_i) |-> (result_o.out_channel_one == 8'd0
                                       && result_o.out_channel_two == 8'd0))
    else $error("gray result carries color channels");

  a_valid_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_i.valid |-> ##3 result_valid_o)
    else $error("request lost in blend pipeline");

endmodule

// ===== sv/image_scale_bilinear_unit.sv =====
// Bilinear scaler. A load beat writes one pixel into the frame store and gives no
// result; a request beat gives exactly one result beat, marked by result_valid_o,
// once past the coordinate, store and blend registers. busy_o is always low: one
// beat enters every cycle, in any mix of loads and requests, because the store is
// split into four row/column parity banks that deliver all four neighbors at once.
// Results cannot be held off and must be taken in the cycle they appear. The user
// writes configuration while no request is in flight, unchecked by the block.
module image_scale_bilinear_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  isb_pkg::item_t                      item_i,
  output logic                                result_valid_o,
  output isb_pkg::result_t                    result_o,
  input  logic                                cfg_we_i,
  input  logic [isb_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [isb_pkg::CfgDataBits-1:0]     cfg_data_i
);

  isb_pkg::cfg_t   cfg_q;
  isb_pkg::coord_t coord;
  isb_pkg::tap_t   tap;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= isb_pkg::SizeBits'(512);
      cfg_q.source_height <= isb_pkg::SizeBits'(512);
      cfg_q.column_step   <= isb_pkg::StepBits'(65536);
      cfg_q.row_step      <= isb_pkg::StepBits'(65536);
      cfg_q.color_mode    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        isb_pkg::CfgSourceWidth:  cfg_q.source_width  <= cfg_data_i[isb_pkg::SizeBits-1:0];
        isb_pkg::CfgSourceHeight: cfg_q.source_height <= cfg_data_i[isb_pkg::SizeBits-1:0];
        isb_pkg::CfgColumnStep:   cfg_q.column_step   <= cfg_data_i[isb_pkg::StepBits-1:0];
        isb_pkg::CfgRowStep:      cfg_q.row_step      <= cfg_data_i[isb_pkg::StepBits-1:0];
        isb_pkg::CfgColorMode:    cfg_q.color_mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  isb_coord u_coord (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .item_i (item_i),
    .cfg_i  (cfg_q),
    .coord_o(coord)
  );

  isb_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coord_i(coord),
    .tap_o  (tap)
  );

  isb_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tap_i         (tap),
    .color_mode_i  (cfg_q.color_mode),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule
